### src/sha384_hash_engine_top_defines.svh
// ---------------------------------------------------------------------------
// sha384 engine assertion macros
// shared concurrent assertion wrappers for the rtl
// ---------------------------------------------------------------------------
`ifndef SHA384_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA384_HASH_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/sha384_pkg.sv
// ---------------------------------------------------------------------------
// sha384 package
// round constants, initial hash values, state codes and a rotate-right helper
// ---------------------------------------------------------------------------
`default_nettype none
package sha384_pkg;
    typedef logic [63:0] t_word;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ROUND = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_PAD   = 4'd3;
    localparam logic [3:0] ST_OUT   = 4'd4;

    function automatic t_word f_iv(input logic [2:0] i);
        case (i)
            3'd0: f_iv = 64'hCBBB9D5DC1059ED8;
            3'd1: f_iv = 64'h629A292A367CD507;
            3'd2: f_iv = 64'h9159015A3070DD17;
            3'd3: f_iv = 64'h152FECD8F70E5939;
            3'd4: f_iv = 64'h67332667FFC00B31;
            3'd5: f_iv = 64'h8EB44A8768581511;
            3'd6: f_iv = 64'hDB0C2E0D64F98FA7;
            default: f_iv = 64'h47B5481DBEFA4FA4;
        endcase
    endfunction

    function automatic t_word f_k(input logic [6:0] i);
        t_word k [80];
        k = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
        f_k = (i < 7'd80) ? k[i] : 64'd0;
    endfunction

    function automatic t_word f_rotr(input t_word x, input int n);
        f_rotr = (x >> n) | (x << (64 - n));
    endfunction
endpackage
`default_nettype wire

### src/sha384_core.sv
// ---------------------------------------------------------------------------
// sha384 compression core
// one sha-512 round per cycle over a rolling 16-word schedule window
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha384_hash_engine_top_defines.svh"
module sha384_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire logic [3:0]          i_wr_idx,
    input  wire sha384_pkg::t_word   i_wr_data,
    input  wire logic                i_start,
    input  wire logic                i_reinit,
    output logic                     o_busy,
    output sha384_pkg::t_word        o_chain [6]
);
    sha384_pkg::t_word r_w [16];
    sha384_pkg::t_word r_h [8];
    sha384_pkg::t_word r_v [8];
    logic [6:0] r_round;
    logic [1:0] r_phase;
    sha384_pkg::t_word w_cur, t1, t2, s0, s1;
    logic [3:0] slot;

    assign slot = r_round[3:0];
    assign o_busy = (r_phase != 2'd0);

    always_comb begin
        s1 = sha384_pkg::f_rotr(r_w[slot + 4'd14], 19) ^ sha384_pkg::f_rotr(r_w[slot + 4'd14], 61)
           ^ (r_w[slot + 4'd14] >> 6);
        s0 = sha384_pkg::f_rotr(r_w[slot + 4'd1], 1) ^ sha384_pkg::f_rotr(r_w[slot + 4'd1], 8)
           ^ (r_w[slot + 4'd1] >> 7);
        w_cur = (r_round >= 7'd16) ? (s1 + r_w[slot + 4'd9] + s0 + r_w[slot]) : r_w[slot];
        t1 = r_v[7] + (sha384_pkg::f_rotr(r_v[4], 14) ^ sha384_pkg::f_rotr(r_v[4], 18)
           ^ sha384_pkg::f_rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha384_pkg::f_k(r_round) + w_cur;
        t2 = (sha384_pkg::f_rotr(r_v[0], 28) ^ sha384_pkg::f_rotr(r_v[0], 34)
           ^ sha384_pkg::f_rotr(r_v[0], 39)) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2])
           ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha384_pkg::f_iv(3'(i));
                r_v[i] <= '0;
            end
        end else begin
            if (i_reinit) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha384_pkg::f_iv(3'(i));
            end
            case (r_phase)
                2'd0: begin
                    if (i_start) begin
                        r_v <= r_h;
                        r_round <= '0;
                        r_phase <= 2'd1;
                    end
                end
                2'd1: begin
                    r_w[slot] <= w_cur;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_round == 7'd79) r_phase <= 2'd2;
                    r_round <= r_round + 7'd1;
                end
                2'd2: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_round <= '0;
                    r_phase <= 2'd0;
                end
                default: r_phase <= 2'd0;
            endcase
        end
        if (i_wr) r_w[i_wr_idx] <= i_wr_data;
    end

    always_comb begin
        for (int i = 0; i < 6; i++) o_chain[i] = r_h[i];
    end

    `SHA_ASSERT_IMPL(a_round_range, i_clk, i_rst_n, r_phase == 2'd1, r_round < 7'd80)
    `SHA_ASSERT_NEXT(a_round_to_add, i_clk, i_rst_n, r_phase == 2'd1 && r_round == 7'd79,
        r_phase == 2'd2)
    `SHA_ASSERT_IMPL(a_no_write_busy, i_clk, i_rst_n, r_phase == 2'd1, !i_wr && !i_start)
endmodule
`default_nettype wire

### src/sha384_hash_engine_top.sv
// ---------------------------------------------------------------------------
// sha384 hash engine top
// a non-final word is stored, or fills a block and starts a compression (80
// rounds on the shared round unit, then chain add); a final word adds padding
// at one word a cycle while the core is idle, one or two compressions, then
// six digest transfers; reset is synchronous, restores initial values
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha384_hash_engine_top_defines.svh"
module sha384_hash_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_data_word,
    input  wire logic        i_last,
    input  wire logic [3:0]  i_last_bytes,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);
    logic [3:0]  r_state;
    logic [3:0]  r_pos;
    logic [127:0] r_len;
    logic        r_pad;
    logic        r_wrap;
    logic [2:0]  r_oidx;
    logic        wr, start, reinit, busy, in_xfer, fin;
    logic [3:0]  wr_idx;
    sha384_pkg::t_word wr_data, n_word, mask;
    sha384_pkg::t_word chain [6];
    logic [3:0]  nb;
    logic [127:0] n_len;

    sha384_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(wr), .i_wr_idx(wr_idx),
        .i_wr_data(wr_data), .i_start(start), .i_reinit(reinit),
        .o_busy(busy), .o_chain(chain)
    );

    assign o_ready = (r_state == sha384_pkg::ST_IDLE) && !busy;
    assign in_xfer = i_valid && o_ready;
    assign nb = (i_last_bytes > 4'd8) ? 4'd8 : i_last_bytes;
    assign o_valid = (r_state == sha384_pkg::ST_OUT);
    assign o_digest_word = chain[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last = (r_oidx == 3'd5);
    assign fin = o_valid && i_ready && (r_oidx == 3'd5);
    assign reinit = fin;

    always_comb begin
        mask = (nb == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - {nb, 3'b000}));
        n_word = (i_data_word & mask)
               | ((nb == 4'd8) ? 64'd0 : (64'h80 << (6'd56 - {nb[2:0], 3'b000})));
        n_len = r_len + ((i_last && nb != 4'd8) ? {121'd0, nb, 3'b000} : 128'd64);
        wr = 1'b0;
        wr_idx = r_pos;
        wr_data = n_word;
        if (in_xfer) begin
            wr = 1'b1;
            wr_data = (!i_last || nb == 4'd8) ? i_data_word : n_word;
        end else if (r_state == sha384_pkg::ST_PAD && !busy) begin
            wr = 1'b1;
            if (r_pad) wr_data = 64'h8000000000000000;
            else if (r_wrap) wr_data = 64'd0;
            else if (r_pos == 4'd14) wr_data = r_len[127:64];
            else if (r_pos == 4'd15) wr_data = r_len[63:0];
            else wr_data = 64'd0;
        end
        start = wr && (r_pos == 4'd15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha384_pkg::ST_IDLE;
            r_pos <= '0;
            r_len <= '0;
            r_pad <= 1'b0;
            r_wrap <= 1'b0;
            r_oidx <= '0;
        end else begin
            case (r_state)
                sha384_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_pos <= r_pos + 4'd1;
                        r_len <= n_len;
                        if (i_last) begin
                            r_state <= sha384_pkg::ST_PAD;
                            r_pad <= (nb == 4'd8);
                            // length does not fit after the marker byte
                            r_wrap <= (nb == 4'd8) ? (r_pos == 4'd13) : (r_pos == 4'd14);
                        end
                    end
                end
                sha384_pkg::ST_PAD: begin
                    if (!busy) begin
                        r_pad <= 1'b0;
                        r_pos <= r_pos + 4'd1;
                        if (r_pos == 4'd15) begin
                            r_wrap <= 1'b0;
                        end
                        if (r_pos == 4'd15 && !r_pad && !r_wrap) begin
                            r_state <= sha384_pkg::ST_ADD;
                        end
                    end
                end
                sha384_pkg::ST_ADD: begin
                    if (!busy && !start) begin
                        r_state <= sha384_pkg::ST_ROUND;
                    end
                end
                sha384_pkg::ST_ROUND: begin
                    if (!busy) begin
                        r_state <= sha384_pkg::ST_OUT;
                        r_oidx <= '0;
                    end
                end
                sha384_pkg::ST_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd5) begin
                            r_state <= sha384_pkg::ST_IDLE;
                            r_oidx <= '0;
                            r_pos <= '0;
                            r_len <= '0;
                        end
                    end
                end
                default: r_state <= sha384_pkg::ST_IDLE;
            endcase
        end
    end

    `SHA_ASSERT_IMPL(a_out_idx, i_clk, i_rst_n, o_valid, o_digest_index <= 3'd5)
    `SHA_ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, busy, !o_ready && !o_valid)
    `SHA_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, fin,
        o_ready || busy || r_state == sha384_pkg::ST_IDLE)
endmodule
`default_nettype wire

### sim/tb_sha384_hash_engine_top.sv
// ---------------------------------------------------------------------------
// sha384 hash engine testbench
// drives message words through the engine with random gaps and stalls,
// predicts each six-word digest with a behavioural sha-384 and checks every
// digest transfer in order
// ---------------------------------------------------------------------------
`default_nettype none
module tb_sha384_hash_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] t_w64;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    localparam t_w64 K_ROUND [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

    localparam t_w64 H_INIT [8] = '{
        64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
        64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};

    localparam int CYCLE_LIMIT = 400000;

    class digest_scoreboard;
        t_w64         hash_state [8];
        t_w64         block_buf [16];
        logic [127:0] msg_bits;
        int           fill;
        t_digest_beat pending_beats [$];
        int           n_errors;
        int           n_digests;

        function new();
            n_errors = 0;
            n_digests = 0;
            restart();
        endfunction

        function void restart();
            hash_state = H_INIT;
            msg_bits = '0;
            fill = 0;
        endfunction

        function t_w64 ror(t_w64 x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress_block();
            t_w64 w [80];
            t_w64 v [8];
            t_w64 t1, t2;
            for (int i = 0; i < 80; i++) begin
                if (i < 16) begin
                    w[i] = block_buf[i];
                end else begin
                    w[i] = (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                         + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
                end
            end
            v = hash_state;
            for (int i = 0; i < 80; i++) begin
                t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[i] + w[i];
                t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_state[i] += v[i];
        endfunction

        function void append_word(t_w64 w);
            block_buf[fill] = w;
            fill = (fill + 1) % 16;
            if (fill == 0) compress_block();
        endfunction

        function void note_transfer(t_w64 data, logic last, logic [3:0] nbytes);
            int   n;
            t_w64 mask;
            t_digest_beat beat;
            if (!last) begin
                msg_bits += 128'd64;
                append_word(data);
                return;
            end
            n = (nbytes > 4'd8) ? 8 : int'(nbytes);
            if (n == 8) begin
                msg_bits += 128'd64;
                append_word(data);
                append_word(64'h80 << 56);
            end else begin
                mask = (n == 0) ? '0 : ({64{1'b1}} << (64 - 8 * n));
                msg_bits += 128'(8 * n);
                append_word((data & mask) | (64'h80 << (56 - 8 * n)));
            end
            if (fill > 14) while (fill != 0) append_word('0);
            while (fill < 14) append_word('0);
            append_word(msg_bits[127:64]);
            append_word(msg_bits[63:0]);
            for (int j = 0; j < 6; j++) begin
                beat.word = hash_state[j];
                beat.index = 3'(j);
                beat.last = (j == 5);
                pending_beats.push_back(beat);
            end
            restart();
        endfunction

        function void check_beat(t_w64 word, logic [2:0] index, logic last);
            t_digest_beat exp_beat;
            if (pending_beats.size() == 0) begin
                $error("digest transfer with nothing expected: word %h", word);
                n_errors++;
                return;
            end
            exp_beat = pending_beats.pop_front();
            if (word !== exp_beat.word) begin
                $error("digest_word expected %h actual %h", exp_beat.word, word);
                n_errors++;
            end
            if (index !== exp_beat.index) begin
                $error("digest_index expected %0d actual %0d", exp_beat.index, index);
                n_errors++;
            end
            if (last !== exp_beat.last) begin
                $error("digest_last expected %0d actual %0d", exp_beat.last, last);
                n_errors++;
            end
            if (last === 1'b1) n_digests++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] in_data = '0;
    logic        in_last = 1'b0;
    logic [3:0]  in_nbytes = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_word;
    logic [2:0]  out_index;
    logic        out_last;

    digest_scoreboard sb = new();
    int  cycle_count = 0;
    int  n_words = 0;
    int  n_messages = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;

    always #5 clk = ~clk;

    sha384_hash_engine_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_data_word    (in_data),
        .i_last         (in_last),
        .i_last_bytes   (in_nbytes),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_digest_word  (out_word),
        .o_digest_index (out_index),
        .o_digest_last  (out_last)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // input transfers noted and digest transfers checked at the edge they happen
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            sb.note_transfer(in_data, in_last, in_nbytes);
            n_words++;
        end
        if (rst_n && out_valid && out_ready) begin
            sb.check_beat(out_word, out_index, out_last);
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int gap;
        int stall;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                out_ready <= 1'b0;
                stall = 0;
                while (stall < 600) begin
                    @(posedge clk);
                    stall++;
                end
                hold_off = 1'b0;
            end
            gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff (out_valid && out_ready) || hold_off);
        end
    end

    task automatic send_word(t_w64 data, logic last, logic [3:0] nbytes, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= data;
        in_last <= last;
        in_nbytes <= nbytes;
        @(posedge clk iff in_ready);
    endtask

    task automatic send_message(int n_full, logic [3:0] nbytes, bit burst);
        t_w64 data;
        for (int i = 0; i < n_full; i++) begin
            data = {$urandom, $urandom};
            send_word(data, 1'b0, 4'($urandom), burst);
        end
        data = {$urandom, $urandom};
        send_word(data, 1'b1, nbytes, burst);
        n_messages++;
    endtask

    initial begin
        int  len;
        bit  burst;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, single word extremes, all byte counts
        send_word('0, 1'b1, 4'd0, 1'b0);
        n_messages++;
        send_word({64{1'b1}}, 1'b1, 4'd8, 1'b0);
        n_messages++;
        send_word('0, 1'b1, 4'd15, 1'b0);
        n_messages++;
        for (int b = 1; b <= 9; b++) begin
            send_word({64{1'b1}}, 1'b1, 4'(b), 1'b0);
            n_messages++;
        end
        // block boundary cases: final word at slot 13, 14, 15
        send_message(13, 4'd8, 1'b0);
        send_message(14, 4'd3, 1'b0);
        send_message(15, 4'd8, 1'b0);

        // long receiver hold-off while words keep coming
        hold_off = 1'b1;
        for (int m = 0; m < 6; m++) send_message(1, 4'd8, 1'b1);

        while (n_words < 360) begin
            burst = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(12, 17);
                2: len = $urandom_range(0, 40);
                default: len = $urandom_range(4, 10);
            endcase
            send_message(len, 4'($urandom), burst);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        @(posedge clk iff sb.pending_beats.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d message words in %0d messages, %0d digests checked",
                 n_words, n_messages, sb.n_digests);
        if (sb.n_errors == 0 && sb.pending_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sha384_hash_engine_top.f
+incdir+src
src/sha384_pkg.sv
src/sha384_core.sv
src/sha384_hash_engine_top.sv
sim/tb_sha384_hash_engine_top.sv
